// ----- sv/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the checksum frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR  = 2'd2;

	localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd255;
	localparam logic [BYTE_W-1:0] BCAST_ADDR_RST  = 8'd128;

	// body position where the payload begins
	localparam logic [COUNT_W-1:0] HDR_LEN_BCAST  = 9'd2;
	localparam logic [COUNT_W-1:0] HDR_LEN_NORMAL = 9'd5;

	// body positions of the header bytes
	localparam logic [COUNT_W-1:0] POS_ADDR   = 9'd0;
	localparam logic [COUNT_W-1:0] POS_CMD_HI = 9'd1;
	localparam logic [COUNT_W-1:0] POS_CMD_LO = 9'd2;
	localparam logic [COUNT_W-1:0] POS_SEQ    = 9'd3;
	localparam logic [COUNT_W-1:0] POS_LEN    = 9'd4;
	localparam logic [COUNT_W-1:0] POS_BLEN   = 9'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] escape_byte;
		logic [BYTE_W-1:0] broadcast_address;
	} cfd_cfg_t;

	typedef struct packed {
		logic              is_end;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] frame_address;
		logic              is_broadcast;
		logic [WORD_W-1:0] command_word;
		logic [BYTE_W-1:0] sequence_number;
		logic [BYTE_W-1:0] payload_length;
		logic              checksum_ok;
		logic [WORD_W-1:0] bad_frame_count;
	} cfd_res_t;

endpackage

// ----- sv/cfd_if.sv -----
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels for received line bytes and deframer results.
// ----------------------------------------------------------------------------
interface cfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
	logic        valid;
	logic        ready;
	logic        is_end;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [7:0]  frame_address;
	logic        is_broadcast;
	logic [15:0] command_word;
	logic [7:0]  sequence_number;
	logic [7:0]  payload_length;
	logic        checksum_ok;
	logic [15:0] bad_frame_count;

	modport source (
		output valid, output is_end, output payload_byte, output payload_index,
		output frame_address, output is_broadcast, output command_word,
		output sequence_number, output payload_length, output checksum_ok,
		output bad_frame_count, input ready
	);
	modport sink (
		input valid, input is_end, input payload_byte, input payload_index,
		input frame_address, input is_broadcast, input command_word,
		input sequence_number, input payload_length, input checksum_ok,
		input bad_frame_count, output ready
	);
endinterface

// ----- sv/cfd_cfg.sv -----
// ----------------------------------------------------------------------------
// cfd_cfg
// Configuration registers: start byte, escape byte, broadcast address.
// ----------------------------------------------------------------------------
module cfd_cfg
	import cfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output cfd_cfg_t             cfg
);

	cfd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte        <= START_BYTE_RST;
			cfg_q.escape_byte       <= ESCAPE_BYTE_RST;
			cfg_q.broadcast_address <= BCAST_ADDR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BYTE:  cfg_q.start_byte        <= cfg_data;
				REG_ESCAPE_BYTE: cfg_q.escape_byte       <= cfg_data;
				REG_BCAST_ADDR:  cfg_q.broadcast_address <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/cfd_parse.sv -----
// ----------------------------------------------------------------------------
// cfd_parse
// Frame state and per-byte decode: de-escaping, header capture, running
// checksum and result formation for one byte per cycle in which fire is set.
// ----------------------------------------------------------------------------
module cfd_parse
	import cfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfd_cfg_t          cfg,
	input  logic              fire,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              has_res,
	output cfd_res_t          res
);

	logic               in_frame_q;
	logic               esc_pend_q;
	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  addr_q;
	logic [WORD_W-1:0]  cmd_q;
	logic [BYTE_W-1:0]  seq_q;
	logic [BYTE_W-1:0]  len_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [WORD_W-1:0]  bad_q;

	logic               in_frame_d;
	logic               esc_pend_d;
	logic [COUNT_W-1:0] count_d;
	logic [BYTE_W-1:0]  addr_d;
	logic [WORD_W-1:0]  cmd_d;
	logic [BYTE_W-1:0]  seq_d;
	logic [BYTE_W-1:0]  len_d;
	logic [BYTE_W-1:0]  sum_d;
	logic [WORD_W-1:0]  bad_d;

	logic               is_start;
	logic               take;
	logic [BYTE_W-1:0]  b;
	logic [BYTE_W-1:0]  addr_eff;
	logic               bcast;
	logic [COUNT_W-1:0] hdr_len;
	logic [COUNT_W-1:0] pay_end;
	logic [COUNT_W-1:0] pay_idx;
	logic               ok;

	assign is_start = (rx_byte == cfg.start_byte);
	// a body byte is taken unless it is a start byte or an unescaped escape byte
	assign take     = in_frame_q && !is_start && (esc_pend_q || rx_byte != cfg.escape_byte);
	assign b        = esc_pend_q ? ~rx_byte : rx_byte;
	assign addr_eff = (count_q == POS_ADDR) ? b : addr_q;
	assign bcast    = (addr_eff == cfg.broadcast_address);
	assign hdr_len  = bcast ? HDR_LEN_BCAST : HDR_LEN_NORMAL;
	assign pay_end  = hdr_len + {1'b0, len_q};
	assign pay_idx  = count_q - hdr_len;
	assign ok       = (sum_q == b);

	always_comb begin
		in_frame_d = in_frame_q;
		esc_pend_d = esc_pend_q;
		count_d    = count_q;
		addr_d     = addr_q;
		cmd_d      = cmd_q;
		seq_d      = seq_q;
		len_d      = len_q;
		sum_d      = sum_q;
		bad_d      = bad_q;
		has_res    = 1'b0;
		res        = '0;
		if (is_start) begin
			in_frame_d = 1'b1;
			esc_pend_d = 1'b0;
			count_d    = '0;
			addr_d     = '0;
			cmd_d      = '0;
			seq_d      = '0;
			len_d      = '0;
			sum_d      = '0;
		end else if (in_frame_q && !take) begin
			esc_pend_d = 1'b1;
		end else if (take) begin
			esc_pend_d = 1'b0;
			addr_d     = addr_eff;
			if (count_q < hdr_len) begin
				if (bcast) begin
					if (count_q == POS_BLEN) len_d = b;
				end else begin
					if (count_q == POS_CMD_HI) cmd_d[WORD_W-1:BYTE_W] = b;
					if (count_q == POS_CMD_LO) cmd_d[BYTE_W-1:0]      = b;
					if (count_q == POS_SEQ)    seq_d = b;
					if (count_q == POS_LEN)    len_d = b;
				end
				sum_d   = sum_q + b;
				count_d = count_q + 1'b1;
			end else if (count_q < pay_end) begin
				sum_d             = sum_q + b;
				count_d           = count_q + 1'b1;
				has_res           = 1'b1;
				res.payload_byte  = b;
				res.payload_index = pay_idx[BYTE_W-1:0];
			end else begin
				// checksum byte closes the frame
				in_frame_d = 1'b0;
				if (!ok && bad_q != '1) bad_d = bad_q + 1'b1;
				has_res             = 1'b1;
				res.is_end          = 1'b1;
				res.frame_address   = addr_eff;
				res.is_broadcast    = bcast;
				res.command_word    = bcast ? '0 : cmd_q;
				res.sequence_number = bcast ? '0 : seq_q;
				res.payload_length  = len_q;
				res.checksum_ok     = ok;
				res.bad_frame_count = bad_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			count_q    <= '0;
			addr_q     <= '0;
			cmd_q      <= '0;
			seq_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			bad_q      <= '0;
		end else if (fire) begin
			in_frame_q <= in_frame_d;
			esc_pend_q <= esc_pend_d;
			count_q    <= count_d;
			addr_q     <= addr_d;
			cmd_q      <= cmd_d;
			seq_q      <= seq_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			bad_q      <= bad_d;
		end
	end

endmodule

// ----- sv/checksum_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// checksum_frame_deframer
// Byte-stuffed serial frame decoder with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one received line byte per cycle and returns each de-escaped payload
// byte as it arrives, then one summary beat per frame carrying the header
// fields, the checksum verdict and the saturating bad-frame count. A byte
// passes an input register, is decoded combinationally against the running
// frame state and lands in a result register; the sustained rate is one byte
// per cycle; the only stall is backpressure from a full result register.
// Configuration registers are written through the plain write port; the user
// must write only with no bytes in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module checksum_frame_deframer
	import cfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	cfd_in_if.sink               in_ch,
	cfd_out_if.source            out_ch
);

	cfd_cfg_t          cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;
	logic              has_res;
	cfd_res_t          res;
	logic              res_valid_q;
	cfd_res_t          res_q;

	cfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves on when the result register is free or draining
	assign adv          = valid_s1 && (!res_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	cfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (adv),
		.rx_byte (byte_s1),
		.has_res (has_res),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= has_res;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			res_q <= res;
		end
	end

	assign out_ch.valid           = res_valid_q;
	assign out_ch.is_end          = res_q.is_end;
	assign out_ch.payload_byte    = res_q.payload_byte;
	assign out_ch.payload_index   = res_q.payload_index;
	assign out_ch.frame_address   = res_q.frame_address;
	assign out_ch.is_broadcast    = res_q.is_broadcast;
	assign out_ch.command_word    = res_q.command_word;
	assign out_ch.sequence_number = res_q.sequence_number;
	assign out_ch.payload_length  = res_q.payload_length;
	assign out_ch.checksum_ok     = res_q.checksum_ok;
	assign out_ch.bad_frame_count = res_q.bad_frame_count;

endmodule
